// ===== sv/bfrf_pkg.sv =====
// Shared types, constants and codes for the binary frame receiver.
package bfrf_pkg;

  localparam int unsigned NUM_ENTRIES = 4;
  localparam logic [15:0] MAX_PAYLOAD = 16'd1024;
  localparam logic [15:0] ANY_LENGTH  = 16'hFFFF;
  localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND = 8'h62;

  typedef logic [NUM_ENTRIES-1:0][31:0] entry_arr_t;
  typedef logic [NUM_ENTRIES-1:0]       entry_mask_t;
  typedef logic [1:0]                   entry_idx_t;

  localparam entry_arr_t ENTRY_RESET = {32'h0002_0005, 32'h0002_0105,
                                        32'h0012_0401, 32'h005C_0701};
  localparam entry_mask_t MASK_RESET = 4'hF;

  typedef enum logic [2:0] {
    CFG_ENTRY0 = 3'd0,
    CFG_ENTRY1 = 3'd1,
    CFG_ENTRY2 = 3'd2,
    CFG_ENTRY3 = 3'd3,
    CFG_MASK   = 3'd4
  } cfg_addr_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CK_ERR  = 2'd2,
    KIND_REJECT  = 2'd3
  } result_kind_t;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK1     = 4'd7,
    PH_CK2     = 4'd8
  } phase_t;

  typedef struct packed {
    logic       hit;
    entry_idx_t entry;
  } match_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   message_class;
    logic [7:0]   message_id;
    entry_idx_t   matched_entry;
    logic [7:0]   payload_value;
    logic [15:0]  payload_index;
    logic [15:0]  frame_length;
  } result_t;

endpackage

// ===== sv/bfrf_if.sv =====
// Handshake channel interfaces: byte input, result output and register writes.
interface bfrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfrf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  message_class;
  logic [7:0]  message_id;
  logic [1:0]  matched_entry;
  logic [7:0]  payload_value;
  logic [15:0] payload_index;
  logic [15:0] frame_length;
  modport source (output valid, output result_kind, output message_class,
                  output message_id, output matched_entry, output payload_value,
                  output payload_index, output frame_length, input ready);
  modport sink   (input valid, input result_kind, input message_class,
                  input message_id, input matched_entry, input payload_value,
                  input payload_index, input frame_length, output ready);
endinterface

interface bfrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [31:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== sv/binary_frame_receiver_fletcher8.sv =====
// Top level: sync-delimited frame receiver with whitelist and Fletcher-8 check.
// Path: each accepted byte is held in the input register, and its result in the result
// register; a result is held there until it is taken, and while it waits parsing stalls.
// Throughput: one byte per cycle; one byte is taken while a result waits, then in ready
// stays low until that result is taken. Cfg writes act the cycle after; cfg ready always high.
// Reset (rst_n low, synchronous): parser hunts for sync, sums and held fields cleared,
// whitelist and enable mask return to their defaults, both stages empty.
module binary_frame_receiver_fletcher8 (
  input logic   clk,
  input logic   rst_n,
  bfrf_in_if.sink    in_ch,
  bfrf_out_if.source out_ch,
  bfrf_cfg_if.sink   cfg_ch
);
  import bfrf_pkg::*;

  entry_arr_t  entries_r;
  entry_mask_t mask_r;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        advance;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] count_r, count_nxt;
  entry_idx_t  entry_r, entry_nxt;

  logic        out_valid_r;
  result_t     res_r, res_nxt;
  logic        emit;

  logic [7:0]  add_a, add_b;
  logic [15:0] len_full, count_inc;
  match_t      match;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRY_RESET;
      mask_r    <= MASK_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_addr_t'(cfg_ch.addr))
        CFG_ENTRY0: entries_r[0] <= cfg_ch.data;
        CFG_ENTRY1: entries_r[1] <= cfg_ch.data;
        CFG_ENTRY2: entries_r[2] <= cfg_ch.data;
        CFG_ENTRY3: entries_r[3] <= cfg_ch.data;
        CFG_MASK:   mask_r       <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Datapath helpers
  assign add_a     = sum_a_r + in_byte_r;
  assign add_b     = sum_b_r + add_a;
  assign len_full  = {in_byte_r, len_r[7:0]};
  assign count_inc = count_r + 16'd1;

  bfrf_match u_match (
    .entries   (entries_r),
    .enable    (mask_r),
    .msg_class (class_r),
    .msg_id    (id_r),
    .msg_len   (len_full),
    .match     (match)
  );

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT2:   phase_nxt = (in_byte_r == SYNC_SECOND) ? PH_CLASS : PH_HUNT1;
      PH_CLASS:   phase_nxt = PH_ID;
      PH_ID:      phase_nxt = PH_LEN1;
      PH_LEN1:    phase_nxt = PH_LEN2;
      PH_LEN2: begin
        if (!match.hit)             phase_nxt = PH_HUNT1;
        else if (len_full != 16'd0) phase_nxt = PH_PAYLOAD;
        else                        phase_nxt = PH_CK1;
      end
      PH_PAYLOAD: phase_nxt = (count_inc >= len_r) ? PH_CK1 : PH_PAYLOAD;
      PH_CK1:     phase_nxt = (in_byte_r == sum_a_r) ? PH_CK2 : PH_HUNT1;
      PH_CK2:     phase_nxt = PH_HUNT1;
      default:    phase_nxt = (in_byte_r == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
    endcase
  end

  // Held fields, sums and result
  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    entry_nxt = entry_r;
    emit      = 1'b0;
    res_nxt   = '0;
    unique case (phase_r)
      PH_HUNT2: begin
        sum_a_nxt = '0;
        sum_b_nxt = '0;
        if (in_byte_r != SYNC_SECOND) count_nxt = '0;
      end
      PH_CLASS: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        class_nxt = in_byte_r;
      end
      PH_ID: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        id_nxt    = in_byte_r;
      end
      PH_LEN1: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        len_nxt   = {8'd0, in_byte_r};
      end
      PH_LEN2: begin
        len_nxt   = len_full;
        count_nxt = '0;
        if (match.hit) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          entry_nxt = match.entry;
        end else begin
          sum_a_nxt             = '0;
          sum_b_nxt             = '0;
          emit                  = 1'b1;
          res_nxt.result_kind   = KIND_REJECT;
          res_nxt.message_class = class_r;
          res_nxt.message_id    = id_r;
          res_nxt.frame_length  = len_full;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt             = add_a;
        sum_b_nxt             = add_b;
        count_nxt             = count_inc;
        emit                  = 1'b1;
        res_nxt.result_kind   = KIND_PAYLOAD;
        res_nxt.message_class = class_r;
        res_nxt.message_id    = id_r;
        res_nxt.matched_entry = entry_r;
        res_nxt.payload_value = in_byte_r;
        res_nxt.payload_index = count_r;
        res_nxt.frame_length  = len_r;
      end
      PH_CK1: begin
        if (in_byte_r != sum_a_r) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          count_nxt = '0;
        end
      end
      PH_CK2: begin
        sum_a_nxt             = '0;
        sum_b_nxt             = '0;
        count_nxt             = '0;
        emit                  = 1'b1;
        res_nxt.result_kind   = (in_byte_r == sum_b_r) ? KIND_GOOD : KIND_CK_ERR;
        res_nxt.message_class = class_r;
        res_nxt.message_id    = id_r;
        res_nxt.matched_entry = entry_r;
        res_nxt.frame_length  = len_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      sum_a_r <= '0;
      sum_b_r <= '0;
      class_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      count_r <= '0;
      entry_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      entry_r <= entry_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = res_r.result_kind;
  assign out_ch.message_class = res_r.message_class;
  assign out_ch.message_id    = res_r.message_id;
  assign out_ch.matched_entry = res_r.matched_entry;
  assign out_ch.payload_value = res_r.payload_value;
  assign out_ch.payload_index = res_r.payload_index;
  assign out_ch.frame_length  = res_r.frame_length;

endmodule

// ===== sv/bfrf_match.sv =====
// Whitelist lookup: lowest enabled entry whose class, id and length fit.
module bfrf_match (
  input  bfrf_pkg::entry_arr_t  entries,
  input  bfrf_pkg::entry_mask_t enable,
  input  logic [7:0]            msg_class,
  input  logic [7:0]            msg_id,
  input  logic [15:0]           msg_len,
  output bfrf_pkg::match_t      match
);
  import bfrf_pkg::*;

  entry_mask_t fits;

  always_comb begin
    for (int n = 0; n < NUM_ENTRIES; n++) begin
      fits[n] = enable[n] && (entries[n][7:0] == msg_class) &&
                (entries[n][15:8] == msg_id) &&
                ((entries[n][31:16] == ANY_LENGTH) ? (msg_len <= MAX_PAYLOAD)
                                                   : (entries[n][31:16] == msg_len));
    end
  end

  always_comb begin
    match = '0;
    for (int n = NUM_ENTRIES - 1; n >= 0; n--) begin
      if (fits[n]) begin
        match.hit   = 1'b1;
        match.entry = entry_idx_t'(n);
      end
    end
  end

endmodule
